[hdl/nur_pkg.sv]
// Package for the not-used-recently replacement block.
// Holds sizes, mode and register codes, and the flag-entry and victim types.
// No dependencies.
package nur_pkg;

    // Number of cache blocks tracked and the address width of the flag memory.
    localparam int NUM_BLOCKS = 64;
    localparam int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Fixed field widths.
    localparam int MODE_W = 3;
    localparam int BLK_W  = 6;
    localparam int CNT_W  = 12;
    localparam int TOT_W  = 32;

    // Command modes.
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REPLACE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INVALIDATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITEBACK  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_DEREF_EN     = 1'b0;
    localparam logic CFG_DEREF_PERIOD = 1'b1;

    // Reset values and the counter preset used by invalidate-all.
    localparam logic [CNT_W-1:0] DEREF_PERIOD_RST = 12'd16;
    localparam logic [CNT_W-1:0] INV_PRESET       = 12'd100;

    // Rank above every real 2*referenced+modified value.
    localparam logic [2:0] RANK_NONE = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;

    // One word of the flag memory.
    typedef struct packed {
        logic valid;
        logic modified;
        logic referenced;
    } t_entry;

    // Outcome of a victim search.
    typedef struct packed {
        logic  found_free;
        t_addr index;
        logic  referenced;
        logic  dirty;
    } t_victim;

endpackage

[hdl/nur_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nur_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 64,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; the read word appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/nur_scan.sv]
// Victim search accumulator: watches one flag word per cycle, when i_valid, in a scan.
// Depends on nur_pkg.
module nur_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_valid,
    input  nur_pkg::t_addr   i_addr,
    input  nur_pkg::t_entry  i_entry,
    output nur_pkg::t_victim o_victim
);
    import nur_pkg::*;

    logic       r_found;
    t_addr      r_free_idx;
    logic       r_free_ref;
    logic [2:0] r_best_rank;
    t_addr      r_best_idx;
    logic       r_best_ref;
    logic       r_best_mod;
    logic [2:0] w_rank;

    assign w_rank = {1'b0, i_entry.referenced, i_entry.modified};

    // Keep the first invalid block and the first block of lowest rank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_found     <= 1'b0;
            r_best_rank <= RANK_NONE;
        end else if (i_valid) begin
            if (!i_entry.valid && !r_found) begin
                r_found    <= 1'b1;
                r_free_idx <= i_addr;
                r_free_ref <= i_entry.referenced;
            end
            if (w_rank < r_best_rank) begin
                r_best_rank <= w_rank;
                r_best_idx  <= i_addr;
                r_best_ref  <= i_entry.referenced;
                r_best_mod  <= i_entry.modified;
            end
        end
    end

    // A free block wins; otherwise the lowest-ranked valid block.
    assign o_victim.found_free = r_found;
    assign o_victim.index      = r_found ? r_free_idx : r_best_idx;
    assign o_victim.referenced = r_found ? r_free_ref : r_best_ref;
    assign o_victim.dirty      = !r_found && r_best_mod;

endmodule

[hdl/nur_replacement_policy.sv]
// Not-used-recently replacement policy for NUM_BLOCKS cache blocks.
// A read, write or write-back edits one flag word by read-modify-write; an access that
// clears the referenced bits, and invalidate-all, sweep all NUM_BLOCKS words; replace
// scans all words and writes the victim; modes that do nothing strobe o_done in the next
// cycle. Commands are taken only while idle; the flag RAM has a single read port.
// After reset the block clears every word of the flag RAM with o_busy high.
// Results cannot be stalled by the receiver. Depends on nur_pkg, nur_ram, nur_scan.
module nur_replacement_policy (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nur_pkg::MODE_W-1:0]  i_mode,
    input  logic [nur_pkg::BLK_W-1:0]   i_block_index,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [nur_pkg::CNT_W-1:0]   i_cfg_wdata,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [nur_pkg::BLK_W-1:0]   o_victim_index,
    output logic                        o_victim_dirty,
    output logic                        o_victim_was_free,
    output logic                        o_deref_done,
    output logic [nur_pkg::TOT_W-1:0]   o_deref_total
);
    import nur_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_VWR  = 3'd4;

    localparam t_addr LAST_ADDR = t_addr'(NUM_BLOCKS - 1);

    // Control and configuration registers.
    logic [2:0]       r_state;
    logic             r_deref_en;
    logic [CNT_W-1:0] r_deref_period;
    logic [CNT_W-1:0] r_acc_cnt;
    logic [TOT_W-1:0] r_deref_cnt;
    logic             r_strobe;
    logic             r_pend;
    logic             r_issue_done;

    // Sweep addresses and the per-word edit of the current item.
    t_addr            r_addr;
    t_addr            r_end;
    t_addr            r_pend_addr;
    t_addr            r_patch_addr;
    logic             r_clr_val;
    logic             r_clr_ref;
    logic             r_set_ref;
    logic             r_set_mod;
    logic             r_clr_mod;

    // Result registers.
    logic [BLK_W-1:0] r_vidx;
    logic             r_vdirty;
    logic             r_vfree;
    logic             r_ddone;

    logic             w_accept;
    logic             w_idx_ok;
    t_addr            w_blk;
    logic             w_counts;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_clear;
    logic             w_last;
    logic             w_hit;
    t_entry           w_rdata;
    t_entry           w_edit;
    t_victim          w_victim;
    logic             w_ram_we;
    t_addr            w_ram_waddr;
    t_entry           w_ram_wdata;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_idx_ok = (32'(i_block_index) < NUM_BLOCKS);
    assign w_blk    = t_addr'(i_block_index);
    assign w_last   = r_pend && (r_pend_addr == r_end);

    // Access counting: reads and writes in range, and invalidate-all with its preset.
    always_comb begin
        w_counts  = r_deref_en &&
                    ((((i_mode == MODE_READ) || (i_mode == MODE_WRITE)) && w_idx_ok) ||
                     (i_mode == MODE_INVALIDATE));
        w_cnt_inc = ((i_mode == MODE_INVALIDATE) ? INV_PRESET : r_acc_cnt) + 12'd1;
        w_clear   = w_counts && (w_cnt_inc >= r_deref_period);
    end

    // Edit applied to each word read back during a read-modify-write sweep.
    always_comb begin
        w_hit             = (r_pend_addr == r_patch_addr);
        w_edit.valid      = r_clr_val ? 1'b0 : w_rdata.valid;
        w_edit.referenced = (w_hit && r_set_ref) ? 1'b1 :
                            (r_clr_ref ? 1'b0 : w_rdata.referenced);
        w_edit.modified   = (w_hit && r_set_mod) ? 1'b1 :
                            ((w_hit && r_clr_mod) ? 1'b0 : w_rdata.modified);
    end

    // Write port of the flag RAM.
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_pend_addr;
        w_ram_wdata = w_edit;
        unique case (r_state)
            S_INIT: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_addr;
                w_ram_wdata = '0;
            end
            S_RMW: begin
                w_ram_we = r_pend;
            end
            S_VWR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = w_victim.index;
                w_ram_wdata = '{valid: 1'b1, modified: 1'b0,
                                referenced: w_victim.referenced};
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    nur_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    nur_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && (i_mode == MODE_REPLACE)),
        .i_valid  (r_pend && (r_state == S_SCAN)),
        .i_addr   (r_pend_addr),
        .i_entry  (w_rdata),
        .o_victim (w_victim)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deref_en     <= 1'b1;
            r_deref_period <= DEREF_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEREF_EN:     r_deref_en     <= i_cfg_wdata[0];
                CFG_DEREF_PERIOD: r_deref_period <= i_cfg_wdata;
                default:          r_deref_en     <= r_deref_en;
            endcase
        end
    end

    // Access and dereference counters, updated when a word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt   <= '0;
            r_deref_cnt <= '0;
        end else if (w_accept && w_counts) begin
            r_acc_cnt   <= w_clear ? '0 : w_cnt_inc;
            r_deref_cnt <= r_deref_cnt + TOT_W'(w_clear);
        end
    end

    // Sequencer: reset clear pass, read-modify-write sweeps and the victim scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_issue_done <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + t_addr'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_issue_done <= 1'b0;
                        r_vidx       <= '0;
                        r_vdirty     <= 1'b0;
                        r_vfree      <= 1'b0;
                        r_ddone      <= w_clear;
                        r_clr_val    <= 1'b0;
                        r_clr_ref    <= w_clear;
                        r_set_ref    <= 1'b0;
                        r_set_mod    <= 1'b0;
                        r_clr_mod    <= 1'b0;
                        r_patch_addr <= w_blk;
                        unique case (i_mode)
                            MODE_READ, MODE_WRITE: begin
                                if (w_idx_ok) begin
                                    r_state   <= S_RMW;
                                    r_set_ref <= 1'b1;
                                    r_set_mod <= (i_mode == MODE_WRITE);
                                    r_addr    <= w_clear ? '0 : w_blk;
                                    r_end     <= w_clear ? LAST_ADDR : w_blk;
                                end else begin
                                    r_strobe <= 1'b1;
                                end
                            end
                            MODE_REPLACE: begin
                                r_state <= S_SCAN;
                                r_addr  <= '0;
                                r_end   <= LAST_ADDR;
                            end
                            MODE_INVALIDATE: begin
                                r_state   <= S_RMW;
                                r_clr_val <= 1'b1;
                                r_addr    <= '0;
                                r_end     <= LAST_ADDR;
                            end
                            MODE_WRITEBACK: begin
                                if (w_idx_ok) begin
                                    r_state   <= S_RMW;
                                    r_clr_mod <= 1'b1;
                                    r_addr    <= w_blk;
                                    r_end     <= w_blk;
                                end else begin
                                    r_strobe <= 1'b1;
                                end
                            end
                            default: begin
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RMW, S_SCAN: begin
                    // Issue one read a cycle; its word comes back with r_pend.
                    if (!r_issue_done) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_addr;
                        if (r_addr == r_end) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + t_addr'(1);
                        end
                    end
                    if (w_last) begin
                        if (r_state == S_RMW) begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_VWR;
                        end
                    end
                end
                S_VWR: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    r_vidx   <= BLK_W'(w_victim.index);
                    r_vdirty <= w_victim.dirty;
                    r_vfree  <= w_victim.found_free;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_strobe;
    assign o_victim_index    = r_vidx;
    assign o_victim_dirty    = r_vdirty;
    assign o_victim_was_free = r_vfree;
    assign o_deref_done      = r_ddone;
    assign o_deref_total     = r_deref_cnt;

    // A read is only in flight while sweeping or scanning.
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_RMW) || (r_state == S_SCAN)))
        else $error("flag read in flight outside a sweep or scan");

    // No result is produced during the reset clear pass.
    a_no_strobe_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_strobe)
        else $error("result strobe during reset clear pass");

    // A taken word either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_busy || o_done))
        else $error("accepted word neither busy nor done");

    // A free victim never needs write-back.
    a_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_victim_was_free && o_victim_dirty))
        else $error("free victim reported dirty");

endmodule
